FILE: design/hdg_pkg.sv
// package: constants, lane types and arctangent table for the haversine geofence pipeline
`timescale 1ns / 1ps

package hdg_pkg;

    // lane count and step counts of the cell chains
    localparam int NLANE        = 4;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;

    // pipeline positions of the sideband chain
    localparam int POS_ROT_INIT = DIV_STEPS + 1;
    localparam int POS_ROT0     = DIV_STEPS + 2;
    localparam int POS_P1       = DIV_STEPS + CORDIC_STEPS + 2;
    localparam int POS_P2       = POS_P1 + 1;
    localparam int POS_P3       = POS_P1 + 2;
    localparam int POS_SQRT0    = POS_P1 + 3;
    localparam int POS_VEC0     = POS_SQRT0 + SQRT_STEPS;
    localparam int POS_D1       = POS_VEC0 + CORDIC_STEPS;
    localparam int DEPTH        = POS_D1 + 1;

    // lane roles
    localparam int LANE_LAT1 = 0;
    localparam int LANE_LAT2 = 1;
    localparam int LANE_DLAT = 2;
    localparam int LANE_DLON = 3;

    // degree-to-angle conversion: q = floor((mag * 2^k + DIV_HALF) / DIV_DEN)
    localparam logic [21:0] DIV_DEN  = 22'd3515625;
    localparam logic [21:0] DIV_HALF = 22'd1757812;

    // fixed point constants
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
    localparam logic signed [31:0] LAT_LIMIT   = 32'sd900000000;
    localparam logic signed [31:0] LON_LIMIT   = 32'sd1800000000;
    localparam logic [29:0]        R_PI_LO     = 30'd828894924;
    localparam logic [63:0]        ROUND_HALF  = 64'h0000_0020_0000_0000;
    localparam logic [24:0]        RADIUS_RST  = 25'd1000;

    typedef struct packed {
        logic        valid;
        logic        err;
    } side_t;

    typedef struct packed {
        logic [21:0] rem;
        logic [31:0] word;
        logic        neg;
    } div_lane_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic               flip;
    } rot_lane_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [33:0] z;
    } vec_lane_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            5'd30:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

FILE: design/hdg_div_cell.sv
// one restoring division step of the degree-to-angle conversion
`timescale 1ns / 1ps

module hdg_div_cell (
    input  logic              clk,
    input  logic              adv,
    input  hdg_pkg::div_lane_t d,
    output hdg_pkg::div_lane_t q
);

    hdg_pkg::div_lane_t q_reg;
    hdg_pkg::div_lane_t q_next;
    logic [22:0]        trial;
    logic [22:0]        diff;
    logic               ge;

    // shift in one numerator bit, subtract the divisor when it fits
    always_comb
    begin
        trial       = {d.rem, d.word[31]};
        diff        = trial - {1'b0, hdg_pkg::DIV_DEN};
        ge          = (trial >= {1'b0, hdg_pkg::DIV_DEN});
        q_next.rem  = ge ? diff[21:0] : trial[21:0];
        q_next.word = {d.word[30:0], ge};
        q_next.neg  = d.neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/hdg_rot_cell.sv
// one rotation step of the sine/cosine cordic
`timescale 1ns / 1ps

module hdg_rot_cell (
    input  logic              clk,
    input  logic              adv,
    input  logic [4:0]        step,
    input  hdg_pkg::rot_lane_t d,
    output hdg_pkg::rot_lane_t q
);

    hdg_pkg::rot_lane_t q_reg;
    hdg_pkg::rot_lane_t q_next;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] at;

    // rotate toward zero residual angle
    always_comb
    begin
        dx          = d.y >>> step;
        dy          = d.x >>> step;
        at          = signed'({1'b0, hdg_pkg::atan_bam(step)});
        q_next.flip = d.flip;
        if (!d.z[32])
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - at;
        end
        else
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/hdg_sqrt_cell.sv
// one bit step of the integer square root
`timescale 1ns / 1ps

module hdg_sqrt_cell (
    input  logic               clk,
    input  logic               adv,
    input  logic [4:0]         step,
    input  hdg_pkg::sqrt_lane_t d,
    output hdg_pkg::sqrt_lane_t q
);

    hdg_pkg::sqrt_lane_t q_reg;
    hdg_pkg::sqrt_lane_t q_next;
    logic [5:0]          sh;
    logic [63:0]         bit_v;
    logic [63:0]         sum;

    // trial subtract of root plus the current bit
    always_comb
    begin
        sh    = 6'd62 - {step, 1'b0};
        bit_v = 64'd1 << sh;
        sum   = d.root + bit_v;
        if (d.rem >= sum)
        begin
            q_next.rem  = d.rem - sum;
            q_next.root = (d.root >> 1) + bit_v;
        end
        else
        begin
            q_next.rem  = d.rem;
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/hdg_vec_cell.sv
// one vectoring step of the atan2 cordic
`timescale 1ns / 1ps

module hdg_vec_cell (
    input  logic              clk,
    input  logic              adv,
    input  logic [4:0]        step,
    input  hdg_pkg::vec_lane_t d,
    output hdg_pkg::vec_lane_t q
);

    hdg_pkg::vec_lane_t q_reg;
    hdg_pkg::vec_lane_t q_next;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [33:0] at;

    // drive y toward zero, accumulate the angle
    always_comb
    begin
        dx = d.y >>> step;
        dy = d.x >>> step;
        at = signed'({2'b00, hdg_pkg::atan_bam(step)});
        if (!d.y[34])
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + at;
        end
        else
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: design/haversine_distance_geofence.sv
// top level: haversine great-circle distance and geofence pipeline
//
// channel  | signals                                           | direction
// input    | in_valid, in_ready, first/second latitude/longitude | in
// result   | out_valid, out_ready, distance_meters, within_radius, coordinate_error | out
// config   | cfg_valid, cfg_ready, geofence_radius               | in
//
// one transaction per cycle while the result is not stalled; data pass through
// 118 pipeline stages, the first loaded at the accepting edge, then the output register
// depth is set by the cell chains: 32 division, 24 rotation, 32 square root, 24 vectoring steps
// reset clears all valid bits and sets the radius to 1000 m
// while a result waits and out_ready is low, the whole chain holds and in_ready is low
`timescale 1ns / 1ps

module haversine_distance_geofence (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] first_latitude,
    input  logic [31:0] first_longitude,
    input  logic [31:0] second_latitude,
    input  logic [31:0] second_longitude,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [24:0] distance_meters,
    output logic        within_radius,
    output logic        coordinate_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] geofence_radius
);

    localparam int NL = hdg_pkg::NLANE;
    localparam int DS = hdg_pkg::DIV_STEPS;
    localparam int CS = hdg_pkg::CORDIC_STEPS;
    localparam int SS = hdg_pkg::SQRT_STEPS;

    logic                adv;
    hdg_pkg::side_t      side_reg [hdg_pkg::DEPTH];
    logic [24:0]         radius_reg;

    hdg_pkg::div_lane_t  div_w [NL][DS+1];
    hdg_pkg::div_lane_t  div_s0_reg [NL];
    hdg_pkg::div_lane_t  div_s0_next [NL];
    logic                err_next;

    hdg_pkg::rot_lane_t  rot_w [NL][CS+1];
    hdg_pkg::rot_lane_t  rot_init_reg [NL];
    hdg_pkg::rot_lane_t  rot_init_next [NL];

    logic signed [32:0]  c1;
    logic signed [32:0]  c2;
    logic signed [32:0]  sdl;
    logic signed [32:0]  sdo;
    logic signed [65:0]  pa;
    logic signed [65:0]  pb;
    logic signed [65:0]  pc;
    logic signed [65:0]  pd;
    logic signed [32:0]  a1_reg;
    logic signed [32:0]  b1_reg;
    logic signed [32:0]  c1_reg;
    logic signed [32:0]  a2_reg;
    logic signed [32:0]  d2_reg;
    logic signed [33:0]  hs;
    logic [30:0]         h;

    hdg_pkg::sqrt_lane_t sq_w [2][SS+1];
    hdg_pkg::sqrt_lane_t sq_init_reg [2];
    hdg_pkg::sqrt_lane_t sq_init_next [2];

    hdg_pkg::vec_lane_t  vec_w [CS+1];

    logic [30:0]         zc;
    logic [60:0]         zlo;
    logic [63:0]         dsum;
    logic [24:0]         dist_reg;

    logic                out_valid_reg;
    logic [24:0]         out_dist_reg;
    logic                out_within_reg;
    logic                out_err_reg;

    // global advance: hold everything while the result register is full and stalled
    assign adv       = !(out_valid_reg && !out_ready);
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= hdg_pkg::RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            radius_reg <= geofence_radius;
        end
    end

    // sideband chain: valid and error flag follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hdg_pkg::DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0].valid <= in_valid;
            side_reg[0].err   <= err_next;
            for (int i = 1; i < hdg_pkg::DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // input stage: range check and division setup per lane
    always_comb
    begin
        logic [31:0]        mag [NL];
        logic signed [32:0] dlat;
        logic signed [32:0] dlon;
        logic [32:0]        ndlat;
        logic [32:0]        ndlon;
        logic [53:0]        num [NL];

        err_next = ($signed(first_latitude) > hdg_pkg::LAT_LIMIT)
                || ($signed(first_latitude) < -hdg_pkg::LAT_LIMIT)
                || ($signed(second_latitude) > hdg_pkg::LAT_LIMIT)
                || ($signed(second_latitude) < -hdg_pkg::LAT_LIMIT)
                || ($signed(first_longitude) > hdg_pkg::LON_LIMIT)
                || ($signed(first_longitude) < -hdg_pkg::LON_LIMIT)
                || ($signed(second_longitude) > hdg_pkg::LON_LIMIT)
                || ($signed(second_longitude) < -hdg_pkg::LON_LIMIT);

        dlat  = $signed({second_latitude[31], second_latitude})
              - $signed({first_latitude[31], first_latitude});
        dlon  = $signed({second_longitude[31], second_longitude})
              - $signed({first_longitude[31], first_longitude});
        ndlat = ~dlat + 33'd1;
        ndlon = ~dlon + 33'd1;

        mag[hdg_pkg::LANE_LAT1] = first_latitude[31] ? (~first_latitude + 32'd1)
                                                     : first_latitude;
        mag[hdg_pkg::LANE_LAT2] = second_latitude[31] ? (~second_latitude + 32'd1)
                                                      : second_latitude;
        mag[hdg_pkg::LANE_DLAT] = dlat[32] ? ndlat[31:0] : dlat[31:0];
        mag[hdg_pkg::LANE_DLON] = dlon[32] ? ndlon[31:0] : dlon[31:0];

        num[hdg_pkg::LANE_LAT1] = {mag[hdg_pkg::LANE_LAT1], 22'd0} + 54'(hdg_pkg::DIV_HALF);
        num[hdg_pkg::LANE_LAT2] = {mag[hdg_pkg::LANE_LAT2], 22'd0} + 54'(hdg_pkg::DIV_HALF);
        num[hdg_pkg::LANE_DLAT] = {1'b0, mag[hdg_pkg::LANE_DLAT], 21'd0}
                                + 54'(hdg_pkg::DIV_HALF);
        num[hdg_pkg::LANE_DLON] = {1'b0, mag[hdg_pkg::LANE_DLON], 21'd0}
                                + 54'(hdg_pkg::DIV_HALF);

        div_s0_next[hdg_pkg::LANE_LAT1].neg = first_latitude[31];
        div_s0_next[hdg_pkg::LANE_LAT2].neg = second_latitude[31];
        div_s0_next[hdg_pkg::LANE_DLAT].neg = dlat[32];
        div_s0_next[hdg_pkg::LANE_DLON].neg = dlon[32];
        for (int l = 0; l < NL; l++)
        begin
            div_s0_next[l].rem  = num[l][53:32];
            div_s0_next[l].word = num[l][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_s0_reg <= div_s0_next;
        end
    end

    // rotation setup: apply sign, fold outer quadrants by a half turn
    always_comb
    begin
        logic [31:0] ang;
        logic        fold;
        logic [31:0] zf;
        for (int l = 0; l < NL; l++)
        begin
            ang  = div_w[l][DS].neg ? (~div_w[l][DS].word + 32'd1) : div_w[l][DS].word;
            fold = ($signed(ang) > 32'sd1073741824) || ($signed(ang) < -32'sd1073741824);
            zf   = fold ? (ang ^ 32'h8000_0000) : ang;
            rot_init_next[l].x    = hdg_pkg::CORDIC_GAIN;
            rot_init_next[l].y    = '0;
            rot_init_next[l].z    = $signed({zf[31], zf});
            rot_init_next[l].flip = fold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_init_reg <= rot_init_next;
        end
    end

    // division and rotation cell chains, one per lane
    genvar gl, gj;
    generate
        for (gl = 0; gl < NL; gl++)
        begin : g_lane
            assign div_w[gl][0] = div_s0_reg[gl];
            for (gj = 0; gj < DS; gj++)
            begin : g_div
                hdg_div_cell u_div (
                    .clk (clk),
                    .adv (adv),
                    .d   (div_w[gl][gj]),
                    .q   (div_w[gl][gj+1])
                );
            end
            assign rot_w[gl][0] = rot_init_reg[gl];
            for (gj = 0; gj < CS; gj++)
            begin : g_rot
                hdg_rot_cell u_rot (
                    .clk  (clk),
                    .adv  (adv),
                    .step (5'(gj)),
                    .d    (rot_w[gl][gj]),
                    .q    (rot_w[gl][gj+1])
                );
            end
        end
    endgenerate

    // product stages: squares and cosine product, then the cosine product times the longitude square
    always_comb
    begin
        c1  = rot_w[hdg_pkg::LANE_LAT1][CS].flip ? -rot_w[hdg_pkg::LANE_LAT1][CS].x
                                                 : rot_w[hdg_pkg::LANE_LAT1][CS].x;
        c2  = rot_w[hdg_pkg::LANE_LAT2][CS].flip ? -rot_w[hdg_pkg::LANE_LAT2][CS].x
                                                 : rot_w[hdg_pkg::LANE_LAT2][CS].x;
        sdl = rot_w[hdg_pkg::LANE_DLAT][CS].flip ? -rot_w[hdg_pkg::LANE_DLAT][CS].y
                                                 : rot_w[hdg_pkg::LANE_DLAT][CS].y;
        sdo = rot_w[hdg_pkg::LANE_DLON][CS].flip ? -rot_w[hdg_pkg::LANE_DLON][CS].y
                                                 : rot_w[hdg_pkg::LANE_DLON][CS].y;
        pa  = sdl * sdl;
        pb  = c1 * c2;
        pc  = sdo * sdo;
        pd  = b1_reg * c1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= 33'(pa >>> 30);
            b1_reg <= 33'(pb >>> 30);
            c1_reg <= 33'(pc >>> 30);
            a2_reg <= a1_reg;
            d2_reg <= 33'(pd >>> 30);
        end
    end

    // h with clamp, then square root operands
    always_comb
    begin
        hs = $signed({a2_reg[32], a2_reg}) + $signed({d2_reg[32], d2_reg});
        if (hs[33])
        begin
            h = '0;
        end
        else if (hs > 34'sd1073741824)
        begin
            h = 31'd1073741824;
        end
        else
        begin
            h = hs[30:0];
        end
        sq_init_next[0].rem  = {3'd0, h, 30'd0};
        sq_init_next[0].root = '0;
        sq_init_next[1].rem  = {3'd0, (31'd1073741824 - h), 30'd0};
        sq_init_next[1].root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_init_reg <= sq_init_next;
        end
    end

    // square root chains: lane 0 gives s, lane 1 gives t
    generate
        for (gl = 0; gl < 2; gl++)
        begin : g_sq
            assign sq_w[gl][0] = sq_init_reg[gl];
            for (gj = 0; gj < SS; gj++)
            begin : g_step
                hdg_sqrt_cell u_sqrt (
                    .clk  (clk),
                    .adv  (adv),
                    .step (5'(gj)),
                    .d    (sq_w[gl][gj]),
                    .q    (sq_w[gl][gj+1])
                );
            end
        end
    endgenerate

    // vectoring chain on (t, s)
    assign vec_w[0].x = $signed({4'd0, sq_w[1][SS].root[30:0]});
    assign vec_w[0].y = $signed({4'd0, sq_w[0][SS].root[30:0]});
    assign vec_w[0].z = '0;

    generate
        for (gj = 0; gj < CS; gj++)
        begin : g_vec
            hdg_vec_cell u_vec (
                .clk  (clk),
                .adv  (adv),
                .step (5'(gj)),
                .d    (vec_w[gj]),
                .q    (vec_w[gj+1])
            );
        end
    endgenerate

    // angle clamp and scaling to meters
    always_comb
    begin
        if (vec_w[CS].z[33])
        begin
            zc = '0;
        end
        else if (vec_w[CS].z > 34'sd1073741824)
        begin
            zc = 31'd1073741824;
        end
        else
        begin
            zc = vec_w[CS].z[30:0];
        end
        zlo  = zc * hdg_pkg::R_PI_LO;
        dsum = {1'b0, zc, 32'd0} + {3'd0, zlo} + hdg_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dsum[62:38];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_reg[hdg_pkg::DEPTH-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_err_reg    <= side_reg[hdg_pkg::DEPTH-1].err;
            out_dist_reg   <= side_reg[hdg_pkg::DEPTH-1].err ? '0 : dist_reg;
            out_within_reg <= !side_reg[hdg_pkg::DEPTH-1].err && (dist_reg <= radius_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign distance_meters  = out_dist_reg;
    assign within_radius    = out_within_reg;
    assign coordinate_error = out_err_reg;

endmodule
